[hdl/fisr_pkg.sv]
// Shared types, constants and bit helpers for the approximate square root pipeline.
package fisr_pkg;

  localparam logic [31:0] SEED_MAGIC  = 32'h5f3759df;
  localparam logic [31:0] F_HALF      = 32'h3f000000;
  localparam logic [31:0] F_ONE_HALF  = 32'h3fc00000;
  localparam logic [31:0] F_POS_INF   = 32'h7f800000;
  localparam logic [31:0] F_QNAN      = 32'h7fc00000;
  localparam logic [33:0] PACK_OVF    = 34'h07f800000;

  // Item as classified by the front part
  typedef struct packed {
    logic        pos;
    logic [31:0] x;
    logic [31:0] seed;
  } fisr_item_t;

  // Sideband that travels alongside each arithmetic unit
  typedef struct packed {
    logic        vld;
    logic        pos;
    logic [31:0] x;
    logic [31:0] half;
    logic [31:0] y;
  } fisr_side_t;

  // Bit position of the most significant set bit (0 when none)
  function automatic logic [5:0] msb48(input logic [47:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) pos = 6'(i);
    end
    return pos;
  endfunction

  // Leading zeros of a 27-bit word (27 when zero)
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (v[i] && !found) begin
        n     = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

[hdl/fisr_if.sv]
// Valid/ready stream interfaces for the input and result channels.
interface fisr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_bits;
  modport source (output valid, output x_bits, input ready);
  modport sink   (input valid, input x_bits, output ready);
endinterface

interface fisr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] root_bits;
  modport source (output valid, output root_bits, input ready);
  modport sink   (input valid, input root_bits, output ready);
endinterface

[hdl/fisr_front.sv]
// Front stage: accepts input beats, classifies them and forms the seed.
module fisr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_x_bits,
  output logic                push_o,
  input  logic                q_ready_i,
  output fisr_pkg::fisr_item_t item_o
);
  import fisr_pkg::*;

  logic       vld_r;
  fisr_item_t item_r;
  logic       take;

  assign push_o   = vld_r && q_ready_i;
  assign in_ready = !vld_r || q_ready_i;
  assign take     = in_valid && in_ready;
  assign item_o   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (push_o) begin
      vld_r <= 1'b0;
    end
  end

  // positive means sign clear, nonzero and not NaN
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.pos  <= (in_x_bits != 32'd0) && (in_x_bits <= F_POS_INF);
      item_r.x    <= in_x_bits;
      item_r.seed <= SEED_MAGIC - {1'b0, in_x_bits[31:1]};
    end
  end

endmodule

[hdl/fisr_queue.sv]
// Two-entry queue between the front and back parts.
module fisr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  fisr_pkg::fisr_item_t item_i,
  output logic                ready_o,
  output logic                vld_o,
  input  logic                pop_i,
  output fisr_pkg::fisr_item_t item_o
);
  import fisr_pkg::*;

  fisr_item_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign ready_o = (cnt_r != 2'd2);
  assign vld_o   = (cnt_r != 2'd0);
  assign item_o  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_r <= ~wr_ptr_r;
      if (pop_i)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({push_i, pop_i})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= item_i;
  end

endmodule

[hdl/fisr_fmul.sv]
// Three-stage binary32 multiplier, round to nearest even, gradual underflow.
module fisr_fmul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [31:0]         a_i,
  input  logic [31:0]         b_i,
  input  fisr_pkg::fisr_side_t side_i,
  output logic [31:0]         res_o,
  output fisr_pkg::fisr_side_t side_o
);
  import fisr_pkg::*;

  // stage 1: unpack and multiply
  logic [7:0]        ea, eb;
  logic [23:0]       ma, mb;
  logic              nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic              s1_sign_r, s1_nan_r, s1_inf_r, s1_zero_r;
  logic signed [9:0] s1_e_r;
  logic [47:0]       s1_p_r;
  fisr_side_t        s1_side_r;

  // stage 2: leading one
  logic              s2_sign_r, s2_nan_r, s2_inf_r, s2_zero_r;
  logic signed [9:0] s2_e_r;
  logic [47:0]       s2_p_r;
  logic [5:0]        s2_l_r;
  fisr_side_t        s2_side_r;

  // stage 3: shift, round, pack
  logic signed [10:0] e11, lsb, lsbc, sh, nsh;
  logic [47:0]        pl;
  logic [111:0]       w;
  logic [5:0]         sc;
  logic [23:0]        m24;
  logic               g, st, rnd;
  logic [24:0]        mr;
  logic [10:0]        fld;
  logic [33:0]        packed_v;
  logic [31:0]        res_nxt;
  logic [31:0]        res_r;
  fisr_side_t         s3_side_r;

  always_comb begin
    ea     = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb     = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma     = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb     = {b_i[30:23] != 8'd0, b_i[22:0]};
    nan_a  = (a_i[30:23] == 8'hff) && (a_i[22:0] != 23'd0);
    nan_b  = (b_i[30:23] == 8'hff) && (b_i[22:0] != 23'd0);
    inf_a  = (a_i[30:23] == 8'hff) && (a_i[22:0] == 23'd0);
    inf_b  = (b_i[30:23] == 8'hff) && (b_i[22:0] == 23'd0);
    zero_a = (a_i[30:0] == 31'd0);
    zero_b = (b_i[30:0] == 31'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign_r <= a_i[31] ^ b_i[31];
      s1_nan_r  <= nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a);
      s1_inf_r  <= inf_a || inf_b;
      s1_zero_r <= zero_a || zero_b;
      s1_e_r    <= $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd300;
      s1_p_r    <= ma * mb;
      s2_sign_r <= s1_sign_r;
      s2_nan_r  <= s1_nan_r;
      s2_inf_r  <= s1_inf_r;
      s2_zero_r <= s1_zero_r;
      s2_e_r    <= s1_e_r;
      s2_p_r    <= s1_p_r;
      s2_l_r    <= msb48(s1_p_r);
      res_r     <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r <= '0;
      s2_side_r <= '0;
      s3_side_r <= '0;
    end else if (en) begin
      s1_side_r <= side_i;
      s2_side_r <= s1_side_r;
      s3_side_r <= s2_side_r;
    end
  end

  always_comb begin
    e11  = {s2_e_r[9], s2_e_r};
    lsb  = $signed({5'b00000, s2_l_r}) - 11'sd23 + e11;
    lsbc = (lsb < -11'sd149) ? -11'sd149 : lsb;
    sh   = lsbc - e11;
    nsh  = -sh;
    sc   = (sh > 11'sd63) ? 6'd63 : sh[5:0];
    pl   = s2_p_r << nsh[4:0];
    w    = {s2_p_r, 64'd0} >> sc;
    if (sh[10]) begin
      m24 = pl[23:0];
      g   = 1'b0;
      st  = 1'b0;
    end else begin
      m24 = w[87:64];
      g   = w[63];
      st  = |w[62:0];
    end
    rnd      = g && (st || m24[0]);
    mr       = {1'b0, m24} + {24'd0, rnd};
    fld      = lsbc + 11'sd149;
    packed_v = {2'b00, fld[8:0], 23'd0} + {9'd0, mr};
    priority if (s2_nan_r) begin
      res_nxt = F_QNAN;
    end else if (s2_inf_r) begin
      res_nxt = {s2_sign_r, F_POS_INF[30:0]};
    end else if (s2_zero_r) begin
      res_nxt = {s2_sign_r, 31'd0};
    end else if (packed_v >= PACK_OVF) begin
      res_nxt = {s2_sign_r, F_POS_INF[30:0]};
    end else begin
      res_nxt = {s2_sign_r, packed_v[30:0]};
    end
  end

  assign res_o  = res_r;
  assign side_o = s3_side_r;

endmodule

[hdl/fisr_fsub.sv]
// Three-stage binary32 subtractor a - b, round to nearest even, gradual underflow.
module fisr_fsub (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [31:0]         a_i,
  input  logic [31:0]         b_i,
  input  fisr_pkg::fisr_side_t side_i,
  output logic [31:0]         res_o,
  output fisr_pkg::fisr_side_t side_o
);
  import fisr_pkg::*;

  // stage 1: order, align, add or subtract
  logic        sa, sb, swap, sub, s_big, s_sml;
  logic [7:0]  ea, eb, e_big, e_sml, d;
  logic [23:0] ma, mb, m_big, m_sml;
  logic [4:0]  dc;
  logic [53:0] w;
  logic [26:0] al, xb;
  logic [27:0] sum;
  logic        nan_a, nan_b, inf_a, inf_b;
  logic        s1_sign_r, s1_nan_r, s1_inf_r, s1_isign_r;
  logic [7:0]  s1_e_r;
  logic [27:0] s1_sum_r;
  fisr_side_t  s1_side_r;

  // stage 2: leading zeros
  logic        s2_sign_r, s2_nan_r, s2_inf_r, s2_isign_r;
  logic [7:0]  s2_e_r;
  logic [27:0] s2_sum_r;
  logic [4:0]  s2_lz_r;
  fisr_side_t  s2_side_r;

  // stage 3: normalise, round, pack
  logic [7:0]  em1, k8;
  logic [8:0]  en9, fm1;
  logic [26:0] m27;
  logic        rnd;
  logic [24:0] mr;
  logic [33:0] packed_v;
  logic [31:0] res_nxt;
  logic [31:0] res_r;
  fisr_side_t  s3_side_r;

  always_comb begin
    sa    = a_i[31];
    sb    = ~b_i[31];
    ea    = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb    = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma    = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb    = {b_i[30:23] != 8'd0, b_i[22:0]};
    nan_a = (a_i[30:23] == 8'hff) && (a_i[22:0] != 23'd0);
    nan_b = (b_i[30:23] == 8'hff) && (b_i[22:0] != 23'd0);
    inf_a = (a_i[30:23] == 8'hff) && (a_i[22:0] == 23'd0);
    inf_b = (b_i[30:23] == 8'hff) && (b_i[22:0] == 23'd0);
    swap  = (b_i[30:0] > a_i[30:0]);
    s_big = swap ? sb : sa;
    s_sml = swap ? sa : sb;
    e_big = swap ? eb : ea;
    e_sml = swap ? ea : eb;
    m_big = swap ? mb : ma;
    m_sml = swap ? ma : mb;
    sub   = s_big ^ s_sml;
    d     = e_big - e_sml;
    dc    = (d > 8'd27) ? 5'd27 : d[4:0];
    w     = {m_sml, 3'b000, 27'd0} >> dc;
    al    = {w[53:28], w[27] | (|w[26:0])};
    xb    = {m_big, 3'b000};
    sum   = sub ? ({1'b0, xb} - {1'b0, al}) : ({1'b0, xb} + {1'b0, al});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // exact cancellation gives +0; like-signed zeros keep their sign
      s1_sign_r  <= (sum == 28'd0) ? (s_big && !sub) : s_big;
      s1_nan_r   <= nan_a || nan_b || (inf_a && inf_b && (sa != sb));
      s1_inf_r   <= inf_a || inf_b;
      s1_isign_r <= inf_a ? sa : sb;
      s1_e_r     <= e_big;
      s1_sum_r   <= sum;
      s2_sign_r  <= s1_sign_r;
      s2_nan_r   <= s1_nan_r;
      s2_inf_r   <= s1_inf_r;
      s2_isign_r <= s1_isign_r;
      s2_e_r     <= s1_e_r;
      s2_sum_r   <= s1_sum_r;
      s2_lz_r    <= lzc27(s1_sum_r[26:0]);
      res_r      <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r <= '0;
      s2_side_r <= '0;
      s3_side_r <= '0;
    end else if (en) begin
      s1_side_r <= side_i;
      s2_side_r <= s1_side_r;
      s3_side_r <= s2_side_r;
    end
  end

  always_comb begin
    em1 = s2_e_r - 8'd1;
    k8  = ({3'b000, s2_lz_r} < em1) ? {3'b000, s2_lz_r} : em1;
    if (s2_sum_r[27]) begin
      m27 = {s2_sum_r[27:2], s2_sum_r[1] | s2_sum_r[0]};
      en9 = {1'b0, s2_e_r} + 9'd1;
    end else begin
      m27 = s2_sum_r[26:0] << k8[4:0];
      en9 = {1'b0, s2_e_r} - {1'b0, k8};
    end
    rnd      = m27[2] && ((|m27[1:0]) || m27[3]);
    mr       = {1'b0, m27[26:3]} + {24'd0, rnd};
    fm1      = en9 - 9'd1;
    packed_v = {2'b00, fm1, 23'd0} + {9'd0, mr};
    priority if (s2_nan_r) begin
      res_nxt = F_QNAN;
    end else if (s2_inf_r) begin
      res_nxt = {s2_isign_r, F_POS_INF[30:0]};
    end else if (s2_sum_r == 28'd0) begin
      res_nxt = {s2_sign_r, 31'd0};
    end else if (packed_v >= PACK_OVF) begin
      res_nxt = {s2_sign_r, F_POS_INF[30:0]};
    end else begin
      res_nxt = {s2_sign_r, packed_v[30:0]};
    end
  end

  assign res_o  = res_r;
  assign side_o = s3_side_r;

endmodule

[hdl/fisr_back.sv]
// Back part: half, two Newton steps and the final product as a chain of float units.
module fisr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_vld_i,
  input  fisr_pkg::fisr_item_t item_i,
  output logic                q_pop_o,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_root_bits
);
  import fisr_pkg::*;

  logic        adv;
  fisr_side_t  s_in, s_h, s_h2, s_t1, s_u1, s_v1, s_y1, s_y1n;
  fisr_side_t  s_t2, s_u2, s_v2, s_y2, s_y2n, s_root;
  logic [31:0] r_half, r_t1, r_u1, r_v1, r_y1, r_t2, r_u2, r_v2, r_y2, r_root;

  // the whole chain advances unless a finished result is held
  assign adv     = out_ready || !s_root.vld;
  assign q_pop_o = adv && q_vld_i;

  always_comb begin
    s_in.vld    = q_vld_i;
    s_in.pos    = item_i.pos;
    s_in.x      = item_i.x;
    s_in.half   = '0;
    s_in.y      = item_i.seed;
    s_h2        = s_h;
    s_h2.half   = r_half;
    s_y1n       = s_y1;
    s_y1n.y     = r_y1;
    s_y2n       = s_y2;
    s_y2n.y     = r_y2;
  end

  fisr_fmul u_half (.clk, .rst_n, .en(adv), .a_i(s_in.x), .b_i(F_HALF),
                    .side_i(s_in), .res_o(r_half), .side_o(s_h));

  fisr_fmul u_t1 (.clk, .rst_n, .en(adv), .a_i(s_h2.half), .b_i(s_h2.y),
                  .side_i(s_h2), .res_o(r_t1), .side_o(s_t1));
  fisr_fmul u_u1 (.clk, .rst_n, .en(adv), .a_i(r_t1), .b_i(s_t1.y),
                  .side_i(s_t1), .res_o(r_u1), .side_o(s_u1));
  fisr_fsub u_v1 (.clk, .rst_n, .en(adv), .a_i(F_ONE_HALF), .b_i(r_u1),
                  .side_i(s_u1), .res_o(r_v1), .side_o(s_v1));
  fisr_fmul u_y1 (.clk, .rst_n, .en(adv), .a_i(s_v1.y), .b_i(r_v1),
                  .side_i(s_v1), .res_o(r_y1), .side_o(s_y1));

  fisr_fmul u_t2 (.clk, .rst_n, .en(adv), .a_i(s_y1n.half), .b_i(s_y1n.y),
                  .side_i(s_y1n), .res_o(r_t2), .side_o(s_t2));
  fisr_fmul u_u2 (.clk, .rst_n, .en(adv), .a_i(r_t2), .b_i(s_t2.y),
                  .side_i(s_t2), .res_o(r_u2), .side_o(s_u2));
  fisr_fsub u_v2 (.clk, .rst_n, .en(adv), .a_i(F_ONE_HALF), .b_i(r_u2),
                  .side_i(s_u2), .res_o(r_v2), .side_o(s_v2));
  fisr_fmul u_y2 (.clk, .rst_n, .en(adv), .a_i(s_v2.y), .b_i(r_v2),
                  .side_i(s_v2), .res_o(r_y2), .side_o(s_y2));

  fisr_fmul u_root (.clk, .rst_n, .en(adv), .a_i(s_y2n.x), .b_i(s_y2n.y),
                    .side_i(s_y2n), .res_o(r_root), .side_o(s_root));

  // drop the arithmetic for zero, negative and NaN inputs
  assign out_valid     = s_root.vld;
  assign out_root_bits = s_root.pos ? r_root : 32'd0;

endmodule

[hdl/fast_inverse_sqrt_float_root.sv]
// Throughput: one beat per cycle; the back chain of ten three-stage float units
// (eight multipliers, two subtractors) advances as one and holds while a result waits.
// A two-entry queue between the classifying front stage and the chain absorbs stalls.
// Reset (rst_n low, synchronous) empties the front stage, the queue and the chain.
module fast_inverse_sqrt_float_root (
  input  logic  clk,
  input  logic  rst_n,
  fisr_in_if.sink    in_ch,
  fisr_out_if.source out_ch
);
  import fisr_pkg::*;

  logic       push;
  logic       q_ready;
  logic       q_vld;
  logic       q_pop;
  fisr_item_t f_item;
  fisr_item_t q_item;

  fisr_front u_front (
    .clk, .rst_n,
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_x_bits (in_ch.x_bits),
    .push_o    (push),
    .q_ready_i (q_ready),
    .item_o    (f_item)
  );

  fisr_queue u_queue (
    .clk, .rst_n,
    .push_i  (push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .vld_o   (q_vld),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  fisr_back u_back (
    .clk, .rst_n,
    .q_vld_i       (q_vld),
    .item_i        (q_item),
    .q_pop_o       (q_pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_root_bits (out_ch.root_bits)
  );

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result beat straight after reset");

  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_ready |-> q_vld)
    else $error("queue full yet empty");

  a_hold_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (q_vld && !q_pop) |-> (out_ch.valid && !out_ch.ready))
    else $error("chain held without an output stall");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> q_vld)
    else $error("pushed beat lost");
`endif

endmodule
